/* src/oet_pkg.sv */
`default_nettype none

package oet_pkg;

	localparam int CAPACITY_DEF    = 64;
	localparam int VERTEX_BITS_DEF = 8;
	localparam int WEIGHT_BITS_DEF = 16;

	// running total width, fixed by the result format
	localparam int SUM_BITS = 22;

	localparam logic [2:0] REQ_APPEND  = 3'd0;
	localparam logic [2:0] REQ_PREPEND = 3'd1;
	localparam logic [2:0] REQ_DELETE  = 3'd2;
	localparam logic [2:0] REQ_QUERY   = 3'd3;
	localparam logic [2:0] REQ_CLEAR   = 3'd4;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_NOMATCH = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} oet_state_t;

endpackage : oet_pkg

`default_nettype wire

/* src/oet_edge_ram.sv */
`default_nettype none

module oet_edge_ram
	import oet_pkg::*;
#(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int WIDTH = 2 * VERTEX_BITS_DEF + WEIGHT_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule : oet_edge_ram

`default_nettype wire

/* src/oet_ctrl.sv */
`default_nettype none

module oet_ctrl
	import oet_pkg::*;
#(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VERTEX_BITS = VERTEX_BITS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	localparam int IDX_W      = $clog2(CAPACITY),
	localparam int CNT_W      = $clog2(CAPACITY + 1),
	localparam int ENTRY_W    = 2 * VERTEX_BITS + WEIGHT_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [2:0]                    req_type,
	input  wire logic [VERTEX_BITS-1:0]        from_vertex,
	input  wire logic [VERTEX_BITS-1:0]        to_vertex,
	input  wire logic signed [WEIGHT_BITS-1:0] edge_weight,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output logic [1:0]                         res_status,
	output logic [CNT_W-1:0]                   res_count,
	output logic [SUM_BITS-1:0]                res_sum,
	output logic                               mem_we,
	output logic [IDX_W-1:0]                   mem_waddr,
	output logic [ENTRY_W-1:0]                 mem_wdata,
	output logic [IDX_W-1:0]                   mem_raddr,
	input  wire logic [ENTRY_W-1:0]            mem_rdata
);

	oet_state_t state_q, state_d;

	logic [IDX_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [SUM_BITS-1:0] sum_q;
	logic [1:0]          status_q;

	logic [VERTEX_BITS-1:0] src_q, dst_q;
	logic [CNT_W-1:0]       iss_pos_q;
	logic [IDX_W-1:0]       rd_ptr_q, wr_ptr_q;
	logic                   v_s1;
	logic [CNT_W-1:0]       pos_s1;
	logic [IDX_W-1:0]       ptr_s1;

	logic                   accept, is_insert, full, issue, hit, miss_end, shift_end;
	logic [IDX_W-1:0]       head_dec, tail_slot, rd_ptr_inc, wr_ptr_inc, ptr_s1_inc;
	logic [IDX_W:0]         tail_sum;
	logic [VERTEX_BITS-1:0] rd_src, rd_dst;
	logic signed [WEIGHT_BITS-1:0] rd_wgt;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign is_insert = (req_type == REQ_APPEND) || (req_type == REQ_PREPEND);
	assign full      = (count_q == CNT_W'(CAPACITY));

	assign head_dec = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - 1'b1;
	assign tail_sum = {1'b0, head_q} + (IDX_W + 1)'(count_q);
	assign tail_slot = (tail_sum >= (IDX_W + 1)'(CAPACITY))
		? IDX_W'(tail_sum - (IDX_W + 1)'(CAPACITY)) : tail_sum[IDX_W-1:0];

	assign rd_ptr_inc = (rd_ptr_q == IDX_W'(CAPACITY - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign wr_ptr_inc = (wr_ptr_q == IDX_W'(CAPACITY - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign ptr_s1_inc = (ptr_s1 == IDX_W'(CAPACITY - 1)) ? '0 : ptr_s1 + 1'b1;

	assign rd_src = mem_rdata[ENTRY_W-1 -: VERTEX_BITS];
	assign rd_dst = mem_rdata[WEIGHT_BITS +: VERTEX_BITS];
	assign rd_wgt = mem_rdata[WEIGHT_BITS-1:0];

	assign issue = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (iss_pos_q < count_q);
	assign hit   = (state_q == S_SCAN) && v_s1 && (rd_src == src_q) && (rd_dst == dst_q);
	assign miss_end  = (state_q == S_SCAN) && v_s1 && !hit
		&& (pos_s1 == count_q - CNT_W'(1));
	assign shift_end = (state_q == S_SHIFT) && !issue && !v_s1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (req_type == REQ_DELETE && count_q != '0) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_SHIFT;
				end else if (miss_end) begin
					state_d = S_DONE;
				end
			end
			S_SHIFT: begin
				if (shift_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory port and result outputs
	always_comb begin
		res_valid  = (state_q == S_DONE);
		res_status = status_q;
		res_count  = count_q;
		res_sum    = sum_q;
		mem_raddr  = rd_ptr_q;
		if (state_q == S_SHIFT) begin
			mem_we    = v_s1;
			mem_waddr = wr_ptr_q;
			mem_wdata = mem_rdata;
		end else begin
			mem_we    = accept && is_insert && !full;
			mem_waddr = (req_type == REQ_PREPEND) ? head_dec : tail_slot;
			mem_wdata = {from_vertex, to_vertex, edge_weight};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				v_s1 <= 1'b0;
				unique case (req_type)
					REQ_APPEND, REQ_PREPEND: begin
						if (!full) begin
							count_q <= count_q + 1'b1;
							sum_q   <= sum_q + SUM_BITS'(edge_weight);
							if (req_type == REQ_PREPEND) begin
								head_q <= head_dec;
							end
						end
					end
					REQ_CLEAR: begin
						head_q  <= '0;
						count_q <= '0;
						sum_q   <= '0;
					end
					default: ;
				endcase
			end else if (state_q == S_SCAN) begin
				if (hit) begin
					sum_q <= sum_q - SUM_BITS'(rd_wgt);
					v_s1  <= 1'b0;
				end else begin
					v_s1 <= issue;
				end
			end else if (state_q == S_SHIFT) begin
				v_s1 <= issue;
				if (shift_end) begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	// request fields and scan pointers
	always_ff @(posedge clk) begin
		if (accept) begin
			src_q     <= from_vertex;
			dst_q     <= to_vertex;
			iss_pos_q <= '0;
			rd_ptr_q  <= head_q;
			if (is_insert && full) begin
				status_q <= STAT_FULL;
			end else if (req_type == REQ_DELETE && count_q == '0) begin
				status_q <= STAT_NOMATCH;
			end else begin
				status_q <= STAT_OK;
			end
		end else if (state_q == S_SCAN) begin
			if (hit) begin
				// restart reads just past the match, writes land on the match
				iss_pos_q <= pos_s1 + 1'b1;
				rd_ptr_q  <= ptr_s1_inc;
				wr_ptr_q  <= ptr_s1;
			end else begin
				if (miss_end) begin
					status_q <= STAT_NOMATCH;
				end
				pos_s1 <= iss_pos_q;
				ptr_s1 <= rd_ptr_q;
				if (issue) begin
					iss_pos_q <= iss_pos_q + 1'b1;
					rd_ptr_q  <= rd_ptr_inc;
				end
			end
		end else if (state_q == S_SHIFT) begin
			if (issue) begin
				iss_pos_q <= iss_pos_q + 1'b1;
				rd_ptr_q  <= rd_ptr_inc;
			end
			if (v_s1) begin
				wr_ptr_q <= wr_ptr_inc;
			end
		end
	end

endmodule : oet_ctrl

`default_nettype wire

/* src/ordered_edge_table.sv */
// Ordered table of weighted edges (source, target, signed weight) kept as a
// ring in one synchronous RAM with one write and one read port.
// Input channel: in_valid / in_stall with req_type, from_vertex, to_vertex,
// edge_weight. Output channel: out_valid / out_stall with status,
// edge_count, total_weight. Every request returns exactly one result.
// A transaction is taken when valid is high and stall is low.
// Append, prepend, query and clear pass from acceptance through the done
// state into the output register. A delete scans the ring through the RAM
// read port one entry per cycle, then closes the gap by copying each later
// entry one slot down, one entry per cycle. One request is in work at a
// time; the next is taken as soon as the previous result has moved into the
// output register, even while that register is stalled.
// Reset empties the table and clears the running total; the RAM keeps its
// contents, since only slots that hold an edge are ever read.
// While out_stall is high the result holds and a finished request waits.
`default_nettype none

module ordered_edge_table
	import oet_pkg::*;
#(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VERTEX_BITS = VERTEX_BITS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [2:0]                    req_type,
	input  wire logic [VERTEX_BITS-1:0]        from_vertex,
	input  wire logic [VERTEX_BITS-1:0]        to_vertex,
	input  wire logic signed [WEIGHT_BITS-1:0] edge_weight,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         status,
	output logic [CNT_W-1:0]                   edge_count,
	output logic signed [SUM_BITS-1:0]         total_weight
);

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int ENTRY_W = 2 * VERTEX_BITS + WEIGHT_BITS;

	logic                res_valid, res_ready;
	logic [1:0]          res_status;
	logic [CNT_W-1:0]    res_count;
	logic [SUM_BITS-1:0] res_sum;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr, mem_raddr;
	logic [ENTRY_W-1:0]  mem_wdata, mem_rdata;

	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [CNT_W-1:0]    count_q;
	logic [SUM_BITS-1:0] sum_q;

	oet_ctrl #(
		.CAPACITY    (CAPACITY),
		.VERTEX_BITS (VERTEX_BITS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.from_vertex (from_vertex),
		.to_vertex   (to_vertex),
		.edge_weight (edge_weight),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_status  (res_status),
		.res_count   (res_count),
		.res_sum     (res_sum),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	oet_edge_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: load when empty or being drained
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			status_q <= res_status;
			count_q  <= res_count;
			sum_q    <= res_sum;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign edge_count   = count_q;
	assign total_weight = sum_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> edge_count <= CNT_W'(CAPACITY))
		else $error("edge count above capacity");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> edge_count == CNT_W'(CAPACITY))
		else $error("full status with room left");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one still in work");

endmodule : ordered_edge_table

`default_nettype wire

/* test/edge_table_checker.sv */
`timescale 1ns / 1ps

module edge_table_checker
	import oet_pkg::*;
(
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic [2:0]                        req_type,
	input  wire logic [VERTEX_BITS_DEF-1:0]        from_vertex,
	input  wire logic [VERTEX_BITS_DEF-1:0]        to_vertex,
	input  wire logic signed [WEIGHT_BITS_DEF-1:0] edge_weight,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic [1:0]                        status,
	input  wire logic [$clog2(CAPACITY_DEF+1)-1:0] edge_count,
	input  wire logic signed [SUM_BITS-1:0]        total_weight,
	output int                                     fail_count,
	output int                                     awaited_count
);

	localparam int CNT_W = $clog2(CAPACITY_DEF + 1);

	typedef logic [VERTEX_BITS_DEF-1:0] vertex_t;
	typedef logic signed [WEIGHT_BITS_DEF-1:0] weight_t;

	typedef struct packed {
		vertex_t src;
		vertex_t dst;
		weight_t wgt;
	} edge_t;

	typedef struct packed {
		logic [1:0]                 status;
		logic [CNT_W-1:0]           count;
		logic signed [SUM_BITS-1:0] total;
	} table_result_t;

	// ordered edge list: index 0 is the first edge in table order
	edge_t                      held_edges[$];
	logic signed [SUM_BITS-1:0] weight_total;
	table_result_t              awaited_results[$];

	function automatic table_result_t apply_request(input logic [2:0] req, input vertex_t src,
			input vertex_t dst, input weight_t wgt);
		table_result_t              res;
		edge_t                      item;
		logic signed [SUM_BITS-1:0] wgt_ext;
		int                         hit;
		res.status = STAT_OK;
		hit = -1;
		item.src = src;
		item.dst = dst;
		item.wgt = wgt;
		wgt_ext = SUM_BITS'(wgt);
		case (req)
			REQ_APPEND, REQ_PREPEND: begin
				if (held_edges.size() >= CAPACITY_DEF) begin
					res.status = STAT_FULL;
				end else begin
					if (req == REQ_APPEND)
						held_edges.push_back(item);
					else
						held_edges.push_front(item);
					weight_total = weight_total + wgt_ext;
				end
			end
			REQ_DELETE: begin
				for (int i = 0; i < held_edges.size(); i++)
					if (hit < 0 && held_edges[i].src == src && held_edges[i].dst == dst)
						hit = i;
				if (hit < 0) begin
					res.status = STAT_NOMATCH;
				end else begin
					wgt_ext = SUM_BITS'(held_edges[hit].wgt);
					weight_total = weight_total - wgt_ext;
					held_edges.delete(hit);
				end
			end
			REQ_CLEAR: begin
				held_edges.delete();
				weight_total = '0;
			end
			default: begin
				// query and spare codes leave the table alone
			end
		endcase
		res.count = CNT_W'(held_edges.size());
		res.total = weight_total;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		table_result_t want;
		if (!arst_n) begin
			held_edges.delete();
			awaited_results.delete();
			weight_total = '0;
			fail_count = 0;
			awaited_count = 0;
		end else begin
			// retire the older result before taking a new transaction
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result with no transaction pending: status %0d count %0d total %0d",
						status, edge_count, total_weight);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fail_count++;
					end
					if (edge_count !== want.count) begin
						$error("edge_count: expected %0d, actual %0d", want.count, edge_count);
						fail_count++;
					end
					if (total_weight !== want.total) begin
						$error("total_weight: expected %0d, actual %0d", want.total,
							total_weight);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(apply_request(req_type, from_vertex, to_vertex,
					edge_weight));
			awaited_count = awaited_results.size();
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import oet_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY_DEF + 1);

	// codes outside the defined request set; the block treats them as a query
	localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

	localparam int RANDOM_ITEMS     = 550;
	localparam int LONG_HOLD_AT     = 150;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int MAX_GAP          = 16;

	typedef logic [VERTEX_BITS_DEF-1:0] vertex_t;
	typedef logic signed [WEIGHT_BITS_DEF-1:0] weight_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [2:0]                 req_type;
	vertex_t                    from_vertex;
	vertex_t                    to_vertex;
	weight_t                    edge_weight;
	logic                       out_valid;
	logic                       out_stall;
	logic [1:0]                 status;
	logic [CNT_W-1:0]           edge_count;
	logic signed [SUM_BITS-1:0] total_weight;

	int fail_count;
	int awaited_count;
	int random_sent;
	int results_taken;
	bit sender_idle;
	bit drain_idle;

	ordered_edge_table u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.from_vertex (from_vertex),
		.to_vertex   (to_vertex),
		.edge_weight (edge_weight),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.edge_count  (edge_count),
		.total_weight(total_weight)
	);

	edge_table_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.from_vertex  (from_vertex),
		.to_vertex    (to_vertex),
		.edge_weight  (edge_weight),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.edge_count   (edge_count),
		.total_weight (total_weight),
		.fail_count   (fail_count),
		.awaited_count(awaited_count)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("ordered_edge_table test failed");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input logic [2:0] req, input vertex_t src, input vertex_t dst,
			input weight_t wgt);
		int gap;
		gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= req;
		from_vertex <= src;
		to_vertex   <= dst;
		edge_weight <= wgt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold off until every transaction in flight has its result
	task automatic drain_table;
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (awaited_count != 0);
	endtask

	// mostly a few vertices so that deletes find matches and duplicates occur
	function automatic vertex_t pick_vertex;
		if ($urandom_range(0, 9) < 7)
			return vertex_t'($urandom_range(0, 3));
		return vertex_t'($urandom_range(0, 255));
	endfunction

	function automatic weight_t pick_weight;
		case ($urandom_range(0, 9))
			0: return weight_t'(1) <<< (WEIGHT_BITS_DEF - 1);
			1: return ~(weight_t'(1) <<< (WEIGHT_BITS_DEF - 1));
			default: return weight_t'($urandom());
		endcase
	endfunction

	function automatic logic [2:0] pick_request;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			return REQ_APPEND;
		if (roll < 60)
			return REQ_PREPEND;
		if (roll < 85)
			return REQ_DELETE;
		if (roll < 92)
			return REQ_QUERY;
		if (roll < 95)
			return REQ_CLEAR;
		return 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
	endfunction

	// clear, fill past capacity, then pull edges out of the full table
	task automatic fill_episode;
		bit      all_low;
		weight_t low_weight;
		low_weight = weight_t'(1) <<< (WEIGHT_BITS_DEF - 1);
		all_low = $urandom_range(0, 2) == 0;
		send_request(REQ_CLEAR, pick_vertex(), pick_vertex(), pick_weight());
		random_sent++;
		for (int i = 0; i < CAPACITY_DEF + 2; i++) begin
			send_request($urandom_range(0, 1) ? REQ_APPEND : REQ_PREPEND, pick_vertex(),
				pick_vertex(), all_low ? low_weight : pick_weight());
			random_sent++;
		end
		for (int i = 0; i < 12; i++) begin
			send_request(REQ_DELETE, pick_vertex(), pick_vertex(), pick_weight());
			random_sent++;
		end
	endtask

	task automatic mixed_episode;
		for (int i = 0; i < 30; i++) begin
			send_request(pick_request(), pick_vertex(), pick_vertex(), pick_weight());
			random_sent++;
		end
	endtask

	// result side: random stall per result, one long hold to back up the block
	initial begin : result_sink
		int hold;
		out_stall = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (results_taken == LONG_HOLD_AT)
				hold = LONG_HOLD_CYCLES;
			else
				hold = drain_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			results_taken++;
			if (results_taken % 25 == 0)
				drain_idle = $urandom_range(0, 2) != 0;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		weight_t w_min;
		weight_t w_max;
		w_min = weight_t'(1) <<< (WEIGHT_BITS_DEF - 1);
		w_max = ~w_min;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_QUERY;
		from_vertex = '0;
		to_vertex = '0;
		edge_weight = '0;
		sender_idle = 1'b0;
		drain_idle = 1'b1;
		random_sent = 0;
		results_taken = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// query and delete on an empty table
		send_request(REQ_QUERY, '0, '0, '0);
		send_request(REQ_DELETE, '0, '0, '0);
		// one edge: a near miss keeps it, the exact pair removes it
		send_request(REQ_APPEND, '0, '0, w_min);
		send_request(REQ_DELETE, vertex_t'(1), '0, '0);
		send_request(REQ_DELETE, '0, '0, w_max);
		send_request(REQ_APPEND, '1, '1, w_max);
		send_request(REQ_PREPEND, '0, '1, weight_t'(-1));
		send_request(REQ_APPEND, '1, '0, weight_t'(1));
		send_request(REQ_APPEND, '0, '1, w_min);
		send_request(REQ_QUERY, '1, '1, w_max);
		// duplicate pair: the first in order goes, then a middle edge
		send_request(REQ_DELETE, '0, '1, '0);
		send_request(REQ_DELETE, '1, '0, '0);
		send_request(REQ_SPARE_FIRST, '1, '1, w_max);
		send_request(REQ_SPARE_FIRST + 3'd1, '0, '0, w_min);
		send_request(REQ_SPARE_LAST, '1, '0, weight_t'(-1));
		send_request(REQ_PREPEND, vertex_t'(128), vertex_t'(127), weight_t'(16384));
		send_request(REQ_DELETE, vertex_t'(128), vertex_t'(127), weight_t'(21930));
		send_request(REQ_DELETE, '1, '1, '0);
		send_request(REQ_CLEAR, '1, '1, w_max);
		send_request(REQ_QUERY, '0, '0, '0);
		send_request(REQ_DELETE, '0, '1, '0);
		drain_table();

		fill_episode();
		while (random_sent < RANDOM_ITEMS) begin
			sender_idle = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 4) == 0)
				fill_episode();
			else
				mixed_episode();
			if ($urandom_range(0, 3) == 0)
				drain_table();
		end

		drain_table();
		repeat (CAPACITY_DEF + 8) @(negedge clk);
		if (fail_count == 0 && awaited_count == 0)
			$display("ordered_edge_table test passed");
		else
			$display("ordered_edge_table test failed");
		$finish;
	end

endmodule
